FILE: sv/fractional_delay_and_sum_beamformer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the fractional delay-and-sum beamformer
// Shared concurrent assertion forms; they expect clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef FRACTIONAL_DELAY_AND_SUM_BEAMFORMER_DEFINES_SVH
`define FRACTIONAL_DELAY_AND_SUM_BEAMFORMER_DEFINES_SVH

// Same-cycle implication
`define FDSB_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("beamformer assertion failed");

// Next-cycle implication
`define FDSB_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("beamformer assertion failed");

`endif

FILE: sv/fdsb_pkg.sv
// ----------------------------------------------------------------------------
// fdsb_pkg
// Shared constants and register codes of the fractional delay beamformer.
// ----------------------------------------------------------------------------
package fdsb_pkg;

    // Default parameter values
    localparam int MAX_DELAY_DEF     = 16;
    localparam int SAMPLE_BITS_DEF   = 24;
    localparam int FRACTION_BITS_DEF = 16;

    // Whole-sample delay register width and the taps it can reach
    localparam int WHOLE_BITS   = 4;
    localparam int TAP_COUNT    = (2 ** WHOLE_BITS) + 1;
    localparam int TAP_IDX_BITS = WHOLE_BITS + 1;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 1;
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        CFG_DELAY_WHOLE    = 1'b0,
        CFG_DELAY_FRACTION = 1'b1
    } cfg_index_t;

endpackage

FILE: sv/fractional_delay_and_sum_beamformer.sv
// ----------------------------------------------------------------------------
// fractional_delay_and_sum_beamformer
// Two-mic delay-and-sum beamformer with linear-interpolated fractional delay.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one sample pair per transaction (mic0 low, mic1 high);
//   m_* returns the target beam (low) and the blocking reference (high).
//   Software loads delay_whole (index 0) and delay_fraction (index 1) on the
//   cfg_* port while the stream is idle; a write takes effect on the edge.
//   Three register stages (tap select, interpolation product, result) lie
//   between an accepted sample pair and its result.
//   Throughput: one transaction per cycle; every stage loads a new
//   transaction each cycle while its successor is free or being emptied.
//   Reset clears the mic1 history to zero, both delay registers to zero and
//   all stage valid flags. When m_tready is low the result register holds,
//   the two earlier stages still fill, and s_tready drops only once all
//   three stages hold data.
// ----------------------------------------------------------------------------
module fractional_delay_and_sum_beamformer #(
    parameter int MAX_DELAY     = fdsb_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS   = fdsb_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = fdsb_pkg::FRACTION_BITS_DEF,
    parameter int DATA_BITS     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [DATA_BITS-1:0]                s_tdata,   // mic0_sample, mic1_sample
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [DATA_BITS-1:0]                m_tdata,   // beam_out, blocking_out
    input  logic                                cfg_we,
    input  logic [fdsb_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [FRACTION_BITS-1:0]            cfg_data
);

    logic [fdsb_pkg::WHOLE_BITS-1:0] delay_whole_reg;
    logic [FRACTION_BITS-1:0]        delay_fraction_reg;
    logic                            tap_valid;
    logic                            tap_ready;
    logic signed [SAMPLE_BITS-1:0]   mic0_in;
    logic signed [SAMPLE_BITS-1:0]   mic1_in;
    logic signed [SAMPLE_BITS-1:0]   tap_mic0;
    logic signed [SAMPLE_BITS-1:0]   tap_a;
    logic signed [SAMPLE_BITS:0]     tap_diff;
    logic signed [SAMPLE_BITS-1:0]   beam;
    logic signed [SAMPLE_BITS-1:0]   blocking;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_whole_reg    <= '0;
            delay_fraction_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (fdsb_pkg::cfg_index_t'(cfg_index))
                fdsb_pkg::CFG_DELAY_WHOLE:
                begin
                    delay_whole_reg <= cfg_data[fdsb_pkg::WHOLE_BITS-1:0];
                end
                fdsb_pkg::CFG_DELAY_FRACTION:
                begin
                    delay_fraction_reg <= cfg_data;
                end
                default:
                begin
                    delay_whole_reg <= delay_whole_reg;
                end
            endcase
        end
    end

    // Unpack input transaction
    assign mic0_in = s_tdata[SAMPLE_BITS-1:0];
    assign mic1_in = s_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS];

    fdsb_taps #(
        .MAX_DELAY   (MAX_DELAY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_taps (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (s_tvalid),
        .in_ready     (s_tready),
        .mic0_in      (mic0_in),
        .mic1_in      (mic1_in),
        .delay_whole  (delay_whole_reg),
        .out_valid    (tap_valid),
        .out_ready    (tap_ready),
        .mic0_out     (tap_mic0),
        .tap_a_out    (tap_a),
        .tap_diff_out (tap_diff)
    );

    fdsb_mix #(
        .SAMPLE_BITS   (SAMPLE_BITS),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_mix (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (tap_valid),
        .in_ready       (tap_ready),
        .mic0_in        (tap_mic0),
        .tap_a_in       (tap_a),
        .tap_diff_in    (tap_diff),
        .delay_fraction (delay_fraction_reg),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .beam_out       (beam),
        .blocking_out   (blocking)
    );

    // Pack output transaction, zero padded to whole bytes
    assign m_tdata = DATA_BITS'({blocking, beam});

endmodule

FILE: sv/fdsb_taps.sv
// ----------------------------------------------------------------------------
// fdsb_taps
// Second-mic history line and tap selection; registers the chosen tap and
// the difference to the next older tap.
// ----------------------------------------------------------------------------
module fdsb_taps #(
    parameter int MAX_DELAY   = fdsb_pkg::MAX_DELAY_DEF,
    parameter int SAMPLE_BITS = fdsb_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_BITS-1:0]         mic0_in,
    input  logic signed [SAMPLE_BITS-1:0]         mic1_in,
    input  logic [fdsb_pkg::WHOLE_BITS-1:0]       delay_whole,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_BITS-1:0]         mic0_out,
    output logic signed [SAMPLE_BITS-1:0]         tap_a_out,
    output logic signed [SAMPLE_BITS:0]           tap_diff_out
);

    logic                          valid_reg;
    logic signed [SAMPLE_BITS-1:0] mic0_reg;
    logic signed [SAMPLE_BITS-1:0] tap_a_reg;
    logic signed [SAMPLE_BITS:0]   tap_diff_reg;
    logic signed [SAMPLE_BITS-1:0] hist_reg [MAX_DELAY];
    logic signed [SAMPLE_BITS-1:0] tap_w [fdsb_pkg::TAP_COUNT];
    logic [fdsb_pkg::TAP_IDX_BITS-1:0] idx_a;
    logic [fdsb_pkg::TAP_IDX_BITS-1:0] idx_b;
    logic signed [SAMPLE_BITS-1:0] tap_a;
    logic signed [SAMPLE_BITS-1:0] tap_b;
    logic signed [SAMPLE_BITS:0]   tap_diff_next;
    logic                          enable;
    logic                          take;

    // Stage moves when empty or when downstream takes its contents
    assign enable   = !valid_reg || out_ready;
    assign in_ready = enable;
    assign take     = in_valid && enable;

    // History shift line, newest sample in entry 0
    genvar gi;
    generate
        for (gi = 0; gi < MAX_DELAY; gi++)
        begin : g_hist
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    hist_reg[gi] <= '0;
                end
                else if (take)
                begin
                    if (gi == 0)
                    begin
                        hist_reg[gi] <= mic1_in;
                    end
                    else
                    begin
                        hist_reg[gi] <= hist_reg[(gi > 0) ? gi - 1 : 0];
                    end
                end
            end
        end
    endgenerate

    // Tap k: current sample, history entry k-1, or zero past the line
    generate
        for (gi = 0; gi < fdsb_pkg::TAP_COUNT; gi++)
        begin : g_tap
            if (gi == 0)
            begin : g_now
                assign tap_w[gi] = mic1_in;
            end
            else if (gi <= MAX_DELAY)
            begin : g_hist_tap
                assign tap_w[gi] = hist_reg[gi - 1];
            end
            else
            begin : g_zero
                assign tap_w[gi] = '0;
            end
        end
    endgenerate

    // Two adjacent taps picked by the whole-sample delay
    assign idx_a = {1'b0, delay_whole};
    assign idx_b = idx_a + fdsb_pkg::TAP_IDX_BITS'(1);
    assign tap_a = tap_w[idx_a];
    assign tap_b = tap_w[idx_b];
    assign tap_diff_next = {tap_b[SAMPLE_BITS-1], tap_b} - {tap_a[SAMPLE_BITS-1], tap_a};

    // Stage valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (enable)
        begin
            valid_reg <= in_valid;
        end
    end

    // Stage payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            mic0_reg     <= mic0_in;
            tap_a_reg    <= tap_a;
            tap_diff_reg <= tap_diff_next;
        end
    end

    assign out_valid    = valid_reg;
    assign mic0_out     = mic0_reg;
    assign tap_a_out    = tap_a_reg;
    assign tap_diff_out = tap_diff_reg;

endmodule

FILE: sv/fdsb_mix.sv
// ----------------------------------------------------------------------------
// fdsb_mix
// Fractional interpolation product, then half sum and half difference into
// the result register.
// ----------------------------------------------------------------------------
`include "fractional_delay_and_sum_beamformer_defines.svh"

module fdsb_mix #(
    parameter int SAMPLE_BITS   = fdsb_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = fdsb_pkg::FRACTION_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] mic0_in,
    input  logic signed [SAMPLE_BITS-1:0] tap_a_in,
    input  logic signed [SAMPLE_BITS:0]   tap_diff_in,
    input  logic [FRACTION_BITS-1:0]      delay_fraction,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] beam_out,
    output logic signed [SAMPLE_BITS-1:0] blocking_out
);

    localparam int PROD_W = FRACTION_BITS + SAMPLE_BITS + 2;
    localparam int WIDE_W = SAMPLE_BITS + 2;

    logic                          prod_valid_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [SAMPLE_BITS-1:0] tap_a_reg;
    logic signed [SAMPLE_BITS-1:0] mic0_reg;
    logic signed [PROD_W-1:0]      prod_next;
    logic signed [PROD_W-1:0]      prod_shifted;
    logic signed [WIDE_W-1:0]      delayed_wide;
    logic signed [SAMPLE_BITS-1:0] delayed;
    logic signed [SAMPLE_BITS:0]   half_sum;
    logic signed [SAMPLE_BITS:0]   half_dif;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] beam_reg;
    logic signed [SAMPLE_BITS-1:0] blocking_reg;
    logic                          prod_en;
    logic                          out_en;

    // Stall chain back from the result register
    assign out_en   = !out_valid_reg || out_ready;
    assign prod_en  = !prod_valid_reg || out_en;
    assign in_ready = prod_en;

    // f * (b - a); delayed = a + floor(product / 2^FRACTION_BITS)
    assign prod_next = PROD_W'($signed({1'b0, delay_fraction})) * PROD_W'(tap_diff_in);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
        end
        else if (prod_en)
        begin
            prod_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && prod_en)
        begin
            prod_reg  <= prod_next;
            tap_a_reg <= tap_a_in;
            mic0_reg  <= mic0_in;
        end
    end

    // Flooring shift, then add back the near tap
    assign prod_shifted = prod_reg >>> FRACTION_BITS;
    assign delayed_wide = WIDE_W'(tap_a_reg) + prod_shifted[WIDE_W-1:0];
    assign delayed      = delayed_wide[SAMPLE_BITS-1:0];

    // Half sum and half difference, floor by dropping the low bit
    assign half_sum = {mic0_reg[SAMPLE_BITS-1], mic0_reg} + {delayed[SAMPLE_BITS-1], delayed};
    assign half_dif = {mic0_reg[SAMPLE_BITS-1], mic0_reg} - {delayed[SAMPLE_BITS-1], delayed};

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_en)
        begin
            out_valid_reg <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (prod_valid_reg && out_en)
        begin
            beam_reg     <= half_sum[SAMPLE_BITS:1];
            blocking_reg <= half_dif[SAMPLE_BITS:1];
        end
    end

    assign out_valid    = out_valid_reg;
    assign beam_out     = beam_reg;
    assign blocking_out = blocking_reg;

    // A product held behind a stalled result is neither lost nor changed
    `FDSB_ASSERT_NEXT(a_prod_held, prod_valid_reg && out_valid_reg && !out_ready, prod_valid_reg && $stable(prod_reg))
    // Upstream is only held off when both stages are full and the output stalls
    `FDSB_ASSERT_NOW(a_ready_low, !in_ready, prod_valid_reg && out_valid_reg && !out_ready)
    // A product moving forward always becomes a result
    `FDSB_ASSERT_NEXT(a_prod_to_out, prod_valid_reg && out_en, out_valid_reg)
    // A transaction taken from the tap stage always lands in the product stage
    `FDSB_ASSERT_NEXT(a_in_to_prod, in_valid && prod_en, prod_valid_reg)

endmodule

FILE: tb/tb_fractional_delay_and_sum_beamformer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the fractional delay-and-sum beamformer
// Streams mic sample pairs under several steering delays and checks every
// beam and blocking result against a cycle-free model of the tapped history
// and interpolation kept in a scoreboard. Both stream sides idle at random.
// ----------------------------------------------------------------------------

// Scoreboard: mirrors the mic1 history and the delay registers, and holds
// the expected results in order.
class beam_scoreboard;
    logic signed [23:0] mic1_hist [16];
    logic [3:0]         whole_delay;
    logic [15:0]        frac_delay;
    logic [47:0]        expected_q [$];
    int                 errors;
    int                 checked;

    function new();
        foreach (mic1_hist[i])
            mic1_hist[i] = '0;
        whole_delay = '0;
        frac_delay  = '0;
        errors      = 0;
        checked     = 0;
    endfunction

    // Register write as seen on the configuration port
    function void set_reg(fdsb_pkg::cfg_index_t idx, logic [15:0] value);
        if (idx == fdsb_pkg::CFG_DELAY_WHOLE)
            whole_delay = value[3:0];
        else if (idx == fdsb_pkg::CFG_DELAY_FRACTION)
            frac_delay = value;
    endfunction

    // Accepted sample pair: compute beam and blocking outputs, shift history
    function void note_pair(logic [47:0] pair);
        longint mic0_val;
        longint mic1_val;
        longint tap_near;
        longint tap_far;
        longint frac_val;
        longint delayed;
        longint beam;
        longint blocking;
        int     d;
        mic0_val = longint'($signed(pair[23:0]));
        mic1_val = longint'($signed(pair[47:24]));
        d        = int'(whole_delay);
        frac_val = longint'({48'd0, frac_delay});
        // tap 0 is the current sample, tap k is history entry k-1
        tap_near = (d == 0) ? mic1_val : longint'(mic1_hist[d - 1]);
        tap_far  = longint'(mic1_hist[d]);
        delayed  = ((65536 - frac_val) * tap_near + frac_val * tap_far) >>> 16;
        beam     = (mic0_val + delayed) >>> 1;
        blocking = (mic0_val - delayed) >>> 1;
        expected_q.push_back({blocking[23:0], beam[23:0]});
        for (int i = 15; i > 0; i--)
            mic1_hist[i] = mic1_hist[i - 1];
        mic1_hist[0] = pair[47:24];
    endfunction

    // Accepted result: compare with the oldest expectation
    function void check_result(logic [47:0] got);
        logic [47:0] want;
        if (expected_q.size() == 0)
        begin
            errors++;
            if (errors <= 10)
                $display("[%0t] unexpected result: beam %0d blocking %0d", $realtime,
                         $signed(got[23:0]), $signed(got[47:24]));
            return;
        end
        want = expected_q.pop_front();
        checked++;
        if (got[23:0] !== want[23:0] || got[47:24] !== want[47:24])
        begin
            errors++;
            if (errors <= 10)
                $display("[%0t] mismatch: beam exp %0d got %0d, blocking exp %0d got %0d",
                         $realtime, $signed(want[23:0]), $signed(got[23:0]),
                         $signed(want[47:24]), $signed(got[47:24]));
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb_fractional_delay_and_sum_beamformer;

    localparam int STALL_LIMIT = 1000;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [47:0]          s_tdata = '0;     // mic0_sample, mic1_sample
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [47:0]          m_tdata;          // beam_out, blocking_out
    logic                 cfg_we = 1'b0;
    fdsb_pkg::cfg_index_t cfg_index = fdsb_pkg::CFG_DELAY_WHOLE;
    logic [15:0]          cfg_data = '0;

    beam_scoreboard sb = new();

    int tx_idle_pct = 26;
    int rx_idle_pct = 58;
    bit rx_hold_req = 1'b0;
    int rx_hold_left = 0;
    int idle_cycles = 0;
    int pairs_sent = 0;
    int settings_used = 0;

    fractional_delay_and_sum_beamformer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Result side backpressure, with an occasional long hold-off
    always @(posedge clk)
    begin
        if (rx_hold_req)
        begin
            rx_hold_left = 64;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0)
        begin
            rx_hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Monitor: register writes, accepted pairs and accepted results
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                sb.note_pair(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_result(m_tdata);
        end
    end

    // Watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            idle_cycles <= 0;
        else if (idle_cycles >= STALL_LIMIT)
        begin
            $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
            $display("Simulation FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // Offer one sample pair and wait for its transaction
    task automatic send_pair(logic [23:0] mic0, logic [23:0] mic1);
        int gap;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {mic1, mic0};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pairs_sent++;
    endtask

    // Hold the input until every expected result is back, then settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Load both delay registers; block must be idle
    task automatic apply_delay(logic [15:0] whole_raw, logic [15:0] frac);
        cfg_we    <= 1'b1;
        cfg_index <= fdsb_pkg::CFG_DELAY_WHOLE;
        cfg_data  <= whole_raw;
        @(posedge clk);
        cfg_index <= fdsb_pkg::CFG_DELAY_FRACTION;
        cfg_data  <= frac;
        @(posedge clk);
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    function automatic logic [23:0] pick_sample();
        case ($urandom_range(15))
            0:       return 24'h7FFFFF;
            1:       return 24'h800000;
            2:       return 24'h000000;
            3:       return 24'hFFFFFF;
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] pick_fraction();
        case ($urandom_range(9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            2:       return 16'h8000;
            3:       return 16'h0001;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        logic [15:0] whole_sel;
        logic [15:0] frac_sel;
        int          phase_items;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero delay from reset, full-scale corners
        send_pair(24'h7FFFFF, 24'h7FFFFF);
        send_pair(24'h800000, 24'h800000);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h800000, 24'h7FFFFF);
        send_pair(24'h000000, 24'h000000);
        send_pair(24'hFFFFFF, 24'hFFFFFF);
        send_pair(24'h000001, 24'hFFFFFF);
        drain();

        // Directed: upper register bits must be ignored, smallest fraction
        apply_delay(16'hFFF3, 16'h0001);
        send_pair(24'h800000, 24'h7FFFFF);
        send_pair(24'h7FFFFF, 24'h800000);
        send_pair(24'h000000, 24'h7FFFFF);
        send_pair(24'hFFFFFF, 24'h800000);
        send_pair(24'h7FFFFF, 24'h000000);
        send_pair(24'h800000, 24'hFFFFFF);
        drain();

        // Directed: deepest tap with the largest fraction
        apply_delay(16'd15, 16'hFFFF);
        for (int i = 0; i < 8; i++)
            send_pair((i % 2) ? 24'h800000 : 24'h7FFFFF,
                      (i % 2) ? 24'h7FFFFF : 24'h800000);
        drain();

        // Random phases, each under a new delay setting
        for (int phase = 0; phase < 8; phase++)
        begin
            case (phase)
                0:       begin whole_sel = 16'd0;  frac_sel = 16'h0000; end
                1:       begin whole_sel = 16'd15; frac_sel = 16'hFFFF; end
                2:       begin whole_sel = 16'd7;  frac_sel = 16'h8000; end
                3:       begin whole_sel = 16'd15; frac_sel = 16'h0000; end
                4:       begin whole_sel = 16'd0;  frac_sel = 16'hFFFF; end
                default: begin
                    whole_sel = 16'($urandom);
                    frac_sel  = pick_fraction();
                end
            endcase
            if (phase < 3)
            begin
                tx_idle_pct = 26;
                rx_idle_pct = 58;
            end
            else if (phase < 6)
            begin
                tx_idle_pct = 58;
                rx_idle_pct = 26;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            apply_delay(whole_sel, frac_sel);
            phase_items = 200;
            for (int i = 0; i < phase_items; i++)
            begin
                // long result-side hold-off while the input keeps streaming
                if (phase == 6 && i == 40)
                    rx_hold_req = 1'b1;
                send_pair(pick_sample(), pick_sample());
            end
            drain();
        end

        drain();
        repeat (8) @(posedge clk);
        sb.errors += sb.pending();

        $display("Ran %0d sample pairs under %0d delay settings; %0d results checked.",
                 pairs_sent, settings_used, sb.checked);
        $display("Mismatches: %0d", sb.errors);
        if (sb.errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
